// File: design/npc_pkg.sv
// ----------------------------------------------------------------------------
// npc_pkg: shared types and constants of the nearest palette color block
// Holds the command codes, the controller states, the pipeline tag that
// travels with each palette read, and the fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package npc_pkg;

  localparam int COLOR_W = 24;            // red, green, blue of 8 bits each
  localparam int ENTRY_W = COLOR_W + 1;   // known mark above the color
  localparam int DIST_W  = 18;

  // Distance reported when no palette entry is known.
  localparam logic [DIST_W-1:0] NO_MATCH_DIST = DIST_W'(3 * 256 * 256);

  typedef enum logic [1:0] {
    MODE_WRITE  = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  // Travels alongside one palette entry through the search pipeline.
  typedef struct packed {
    logic live;   // the stage holds an entry of the current search
    logic last;   // it is the highest palette slot
    logic known;  // the entry carries a valid color
  } tag_t;

endpackage

`default_nettype wire

// File: design/nearest_palette_color.sv
// ----------------------------------------------------------------------------
// nearest_palette_color: palette store with nearest color search
// Keeps PALETTE_DEPTH colors with known marks in one synchronous memory and
// finds the known entry closest to a query color by squared RGB distance.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Transfer
//  --------  ----------------------------------------  --------------------------
//  command   start, busy, mode, entry_index,           start high and busy low
//            red, green, blue
//  result    result_valid, best_index,                 every cycle result_valid
//            best_distance, found                      is high (one cycle wide)
//
//  A write or remove command leaves busy low, and the next
//  command may follow at once.
//  A query scans the whole palette, reading one memory entry per cycle
//  over the single read port; each entry then passes the distance stage
//  and the compare stage.
//  A clear command, and reset, run a clearing pass that writes every memory
//  entry as unknown, one per cycle, with busy high.
//  The receiver cannot stall; a result is on the ports for one cycle only.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color #(
  parameter int PALETTE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [5:0]  entry_index,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        result_valid,
  output logic [5:0]  best_index,
  output logic [17:0] best_distance,
  output logic        found
);
  import npc_pkg::*;

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(PALETTE_DEPTH - 1);

  // Each word holds the known mark in its top bit and the color below it.
  logic [ENTRY_W-1:0] mem [PALETTE_DEPTH];

  state_t             state, state_next;
  logic [IDX_W-1:0]   addr, addr_next;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic               feed;
  logic               query_start;
  logic               in_range;

  logic [COLOR_W-1:0] query_color;
  logic [ENTRY_W-1:0] rd_word;
  logic [IDX_W-1:0]   rd_idx;
  tag_t               rd_tag;
  tag_t               dist_tag_in;

  logic [DIST_W-1:0]  cmp_dist;
  tag_t               cmp_tag;
  logic [IDX_W-1:0]   cmp_idx;

  logic [DIST_W-1:0]  best_d, best_d_next;
  logic [IDX_W-1:0]   best_i, best_i_next;
  logic               any_known, any_known_next;
  logic               better;
  logic               scan_done;

  assign busy     = (state != ST_IDLE);
  // Slots at or above the palette depth are ignored by write and remove.
  assign in_range = (32'(entry_index) < PALETTE_DEPTH);

  // Controller: clearing pass, command decode and the query scan.
  always_comb begin
    state_next  = state;
    addr_next   = addr;
    mem_we      = 1'b0;
    mem_waddr   = IDX_W'(entry_index);
    mem_wdata   = {1'b1, red, green, blue};
    feed        = 1'b0;
    query_start = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = addr;
        mem_wdata = '0;
        addr_next = addr + 1'b1;
        if (addr == LAST_ADDR) begin
          state_next = ST_IDLE;
          addr_next  = '0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          unique case (mode_t'(mode))
            MODE_WRITE: begin
              mem_we = in_range;
            end
            MODE_REMOVE: begin
              mem_we    = in_range;
              mem_wdata = '0;
            end
            MODE_CLEAR: begin
              state_next = ST_CLEAR;
              addr_next  = '0;
            end
            MODE_QUERY: begin
              state_next  = ST_SCAN;
              addr_next   = '0;
              query_start = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        feed      = 1'b1;
        addr_next = addr + 1'b1;
        if (addr == LAST_ADDR) begin
          state_next = ST_WAIT;
          addr_next  = '0;
        end
      end
      ST_WAIT: begin
        // The highest slot leaves the compare stage; the result goes out.
        if (scan_done) begin
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      addr  <= '0;
    end else begin
      state <= state_next;
      addr  <= addr_next;
    end
  end

  // Palette memory: one write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word <= mem[addr];
    rd_idx  <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_tag <= '0;
    end else begin
      rd_tag <= '{live: feed, last: (addr == LAST_ADDR), known: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      query_color <= {red, green, blue};
    end
  end

  assign dist_tag_in = '{live: rd_tag.live, last: rd_tag.last,
                         known: rd_word[ENTRY_W-1]};

  npc_dist #(
    .IDX_W (IDX_W)
  ) u_dist (
    .clk         (clk),
    .rst         (rst),
    .query_color (query_color),
    .entry_color (rd_word[COLOR_W-1:0]),
    .tag_in      (dist_tag_in),
    .idx_in      (rd_idx),
    .sq_dist     (cmp_dist),
    .tag_out     (cmp_tag),
    .idx_out     (cmp_idx)
  );

  // Compare stage. Only a strictly smaller distance replaces the best, so on
  // a tie the lowest slot wins. Any known entry beats the no-match distance.
  always_comb begin
    better         = cmp_tag.live && cmp_tag.known && (cmp_dist < best_d);
    best_d_next    = better ? cmp_dist : best_d;
    best_i_next    = better ? cmp_idx : best_i;
    any_known_next = any_known | (cmp_tag.live & cmp_tag.known);
    scan_done      = (state == ST_WAIT) && cmp_tag.live && cmp_tag.last;
  end

  always_ff @(posedge clk) begin
    if (query_start) begin
      best_d    <= NO_MATCH_DIST;
      best_i    <= '0;
      any_known <= 1'b0;
    end else begin
      best_d    <= best_d_next;
      best_i    <= best_i_next;
      any_known <= any_known_next;
    end
  end

  // Result registers: the slot number is reported by its low six bits.
  always_ff @(posedge clk) begin
    if (scan_done) begin
      best_index    <= 6'(best_i_next);
      best_distance <= best_d_next;
      found         <= any_known_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= scan_done;
    end
  end

  // A result appears only once the search has finished and the block is free.
  a_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy)
    else $error("result strobe while the block is busy");

  // No entry of a search may still be in flight when commands are taken.
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (!rd_tag.live && !cmp_tag.live))
    else $error("search pipeline not empty while idle");

  a_no_match: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !found) |-> (best_distance == NO_MATCH_DIST && best_index == 6'd0))
    else $error("empty palette result carries wrong index or distance");

  a_match_dist: assert property (@(posedge clk) disable iff (rst)
    (result_valid && found) |-> (best_distance < NO_MATCH_DIST))
    else $error("found result carries the no-match distance");

endmodule

`default_nettype wire

// File: design/npc_dist.sv
// ----------------------------------------------------------------------------
// npc_dist: squared RGB distance stage
// Computes the squared Euclidean distance between the query color and one
// palette color and registers it together with the entry's tag and slot.
// ----------------------------------------------------------------------------
`default_nettype none

module npc_dist #(
  parameter int IDX_W = 6
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [npc_pkg::COLOR_W-1:0] query_color,
  input  logic [npc_pkg::COLOR_W-1:0] entry_color,
  input  npc_pkg::tag_t             tag_in,
  input  logic [IDX_W-1:0]          idx_in,
  output logic [npc_pkg::DIST_W-1:0] sq_dist,
  output npc_pkg::tag_t             tag_out,
  output logic [IDX_W-1:0]          idx_out
);
  import npc_pkg::*;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return 16'(d) * 16'(d);
  endfunction

  logic [15:0] sq_r, sq_g, sq_b;
  logic [DIST_W-1:0] sum;

  always_comb begin
    sq_r = sq_diff(query_color[23:16], entry_color[23:16]);
    sq_g = sq_diff(query_color[15:8],  entry_color[15:8]);
    sq_b = sq_diff(query_color[7:0],   entry_color[7:0]);
    sum  = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  always_ff @(posedge clk) begin
    sq_dist <= sum;
    idx_out <= idx_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

endmodule

`default_nettype wire

// File: tb/nearest_palette_color_tb.sv
// ----------------------------------------------------------------------------
// nearest_palette_color_tb: self-checking bench for the palette color search
// Drives write, remove, clear and query commands through the start/busy
// handshake. A scoreboard keeps its own copy of the palette and predicts
// each query's answer. Every strobed result is checked against the oldest
// prediction. A short directed part runs first, then weighted random
// traffic with random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module nearest_palette_color_tb;

  import npc_pkg::*;

  localparam int PALETTE_DEPTH = 64;
  localparam int RANDOM_ITEMS  = 1250;
  // Wait budget for one query, used to size the drain limits.
  localparam int SCAN_CYCLES   = PALETTE_DEPTH + 3;
  localparam int DRAIN_LIMIT   = 20 * SCAN_CYCLES;
  // The slowest correct run is about 1300 items, each waiting out at most
  // the longest gap, a full scan and a clearing pass. At 4 time units per
  // cycle this limit is several times what such a run needs.
  localparam int RUN_LIMIT     = 4_000_000;

  // One predicted answer to a query.
  typedef struct packed {
    logic [5:0]        index;
    logic [DIST_W-1:0] distance;
    logic              found;
  } match_t;

  // Keeps a shadow palette, predicts query answers, and checks results.
  class palette_scoreboard;
    logic [COLOR_W-1:0] colors [PALETTE_DEPTH];
    bit                 known  [PALETTE_DEPTH];
    match_t             pending_matches [$];
    int unsigned        failures;

    function new();
      foreach (known[i]) begin
        known[i]  = 1'b0;
        colors[i] = '0;
      end
      failures = 0;
    endfunction

    // Full scan in ascending slot order. Only a strictly smaller distance
    // replaces the best so far, so the lowest slot wins a tie.
    function match_t nearest_match(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      match_t m;
      int     dr, dg, db, d;
      m.index    = '0;
      m.distance = NO_MATCH_DIST;
      m.found    = 1'b0;
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
        if (known[i]) begin
          dr = int'(r) - int'(colors[i][23:16]);
          dg = int'(g) - int'(colors[i][15:8]);
          db = int'(b) - int'(colors[i][7:0]);
          d  = dr * dr + dg * dg + db * db;
          m.found = 1'b1;
          if (d < int'(m.distance)) begin
            m.distance = DIST_W'(d);
            m.index    = 6'(i);
          end
        end
      end
      return m;
    endfunction

    // Called for every accepted command transfer.
    function void note_command(mode_t m, logic [5:0] slot,
                               logic [7:0] r, logic [7:0] g, logic [7:0] b);
      case (m)
        MODE_WRITE: begin
          if (int'(slot) < PALETTE_DEPTH) begin
            colors[slot] = {r, g, b};
            known[slot]  = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (int'(slot) < PALETTE_DEPTH) known[slot] = 1'b0;
        end
        MODE_CLEAR: begin
          foreach (known[i]) known[i] = 1'b0;
        end
        default: begin
          pending_matches = {pending_matches, nearest_match(r, g, b)};
        end
      endcase
    endfunction

    // Called for every strobed result.
    function void check_result(logic [5:0] idx, logic [DIST_W-1:0] got_dist, logic fnd);
      match_t want;
      if (pending_matches.size() == 0) begin
        $error("result with no query waiting: best_index %0d best_distance %0d found %0b",
               idx, got_dist, fnd);
        failures++;
        return;
      end
      want = pending_matches.pop_front();
      if (idx !== want.index) begin
        $error("best_index: expected %0d, actual %0d", want.index, idx);
        failures++;
      end
      if (got_dist !== want.distance) begin
        $error("best_distance: expected %0d, actual %0d", want.distance, got_dist);
        failures++;
      end
      if (fnd !== want.found) begin
        $error("found: expected %0b, actual %0b", want.found, fnd);
        failures++;
      end
    endfunction

    function int pending();
      return pending_matches.size();
    endfunction

    // Draws a color that is currently in the palette, used to aim queries
    // at exact matches and to plant duplicate colors for ties.
    function bit pick_known(output logic [COLOR_W-1:0] c);
      int s;
      c = '0;
      for (int k = 0; k < 16; k++) begin
        s = $urandom_range(0, PALETTE_DEPTH - 1);
        if (known[s]) begin
          c = colors[s];
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [1:0]        mode;
  logic [5:0]        entry_index;
  logic [7:0]        red;
  logic [7:0]        green;
  logic [7:0]        blue;
  logic              result_valid;
  logic [5:0]        best_index;
  logic [DIST_W-1:0] best_distance;
  logic              found;

  palette_scoreboard sb = new();

  // Remaining items of the current back-to-back stretch.
  int burst_left = 0;

  nearest_palette_color #(
    .PALETTE_DEPTH(PALETTE_DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .result_valid (result_valid),
    .best_index   (best_index),
    .best_distance(best_distance),
    .found        (found)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Independent watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    #(RUN_LIMIT);
    $display("nearest_palette_color test failed");
    $finish;
  end

  // Results cannot be held off, so every strobed cycle is checked at the
  // rising edge that ends it.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      sb.check_result(best_index, best_distance, found);
    end
  end

  // Sender gap for the next item: usually random, but now and then a
  // stretch of items goes back to back with no gap at all.
  function automatic int next_gap();
    if (burst_left == 0 && $urandom_range(0, 29) == 0) begin
      burst_left = $urandom_range(10, 40);
    end
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Channels favor the two extremes so that maximum distances occur often.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Moves a channel by up to three steps either way, clamped to the 8-bit range,
  // so that a query lands at or close to a stored color.
  function automatic logic [7:0] nudge(logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 6)) - 3;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return 8'(t);
  endfunction

  // Presents one command and holds it until it transfers. The task is entered
  // just after a rising edge; fields change only at falling edges. When
  // hold_off is set, start stays low until every pending query has answered.
  task automatic send_command(mode_t m, logic [5:0] slot, logic [7:0] r,
                              logic [7:0] g, logic [7:0] b, int gap, bit hold_off);
    @(negedge clk);
    if (gap > 0 || (hold_off && sb.pending() != 0)) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
      while (hold_off && sb.pending() != 0) @(negedge clk);
    end
    start       <= 1'b1;
    mode        <= m;
    entry_index <= slot;
    red         <= r;
    green       <= g;
    blue        <= b;
    // Transfer happens at the first rising edge that sees busy low.
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_command(m, slot, r, g, b);
  endtask

  initial begin
    mode_t              m;
    logic [5:0]         slot;
    logic [7:0]         r, g, b;
    logic [COLOR_W-1:0] c;
    int                 roll;
    int                 aim;
    int                 guard;

    rst         = 1'b1;
    start       = 1'b0;
    mode        = MODE_WRITE;
    entry_index = '0;
    red         = '0;
    green       = '0;
    blue        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The first query runs right behind the clearing pass
    // that follows reset and must see an empty palette.
    send_command(MODE_QUERY,  6'd0,  8'd10,  8'd20,  8'd30,  next_gap(), 1'b0);
    send_command(MODE_WRITE,  6'd0,  8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);
    send_command(MODE_WRITE,  6'd63, 8'd255, 8'd255, 8'd255, next_gap(), 1'b0);
    // Exact matches at the first and the last slot; the scan still runs to the highest slot.
    send_command(MODE_QUERY,  6'd0,  8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd0,  8'd255, 8'd255, 8'd255, next_gap(), 1'b0);
    // Just either side of the midpoint between black and white.
    send_command(MODE_QUERY,  6'd0,  8'd128, 8'd128, 8'd128, next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd0,  8'd127, 8'd127, 8'd127, next_gap(), 1'b0);
    // Two slots hold the same color, so the lower one must win the tie.
    send_command(MODE_WRITE,  6'd40, 8'd100, 8'd50,  8'd25,  next_gap(), 1'b0);
    send_command(MODE_WRITE,  6'd30, 8'd100, 8'd50,  8'd25,  next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd0,  8'd101, 8'd50,  8'd25,  next_gap(), 1'b0);
    send_command(MODE_REMOVE, 6'd30, 8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd0,  8'd101, 8'd50,  8'd25,  next_gap(), 1'b0);
    // Overwrite of a known slot, and removal of a slot never written.
    send_command(MODE_WRITE,  6'd40, 8'd200, 8'd10,  8'd240, next_gap(), 1'b0);
    send_command(MODE_REMOVE, 6'd5,  8'd255, 8'd255, 8'd255, next_gap(), 1'b0);
    send_command(MODE_REMOVE, 6'd0,  8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd0,  8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);
    // Clear carries junk in its ignored fields; the query after it has a
    // nonzero index that must be ignored too and sees an empty palette.
    send_command(MODE_CLEAR,  6'd63, 8'd255, 8'd0,   8'd255, next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd63, 8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);
    // Largest possible distance between a stored and a queried color.
    send_command(MODE_WRITE,  6'd17, 8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd0,  8'd255, 8'd255, 8'd255, next_gap(), 1'b0);
    send_command(MODE_WRITE,  6'd0,  8'd255, 8'd0,   8'd255, next_gap(), 1'b0);
    send_command(MODE_WRITE,  6'd63, 8'd0,   8'd255, 8'd0,   next_gap(), 1'b0);
    send_command(MODE_QUERY,  6'd21, 8'd0,   8'd255, 8'd0,   next_gap(), 1'b0);
    send_command(MODE_CLEAR,  6'd0,  8'd0,   8'd0,   8'd0,   next_gap(), 1'b0);

    // Random part. Writes outnumber removes so that the palette fills up,
    // clears are rare, and many queries aim at or near stored colors. The
    // sender waits for all pending answers before the first random item and
    // again halfway through.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      slot = 6'($urandom_range(0, 63));
      r    = pick_channel();
      g    = pick_channel();
      b    = pick_channel();
      if (roll < 40) begin
        m = MODE_WRITE;
        if ($urandom_range(0, 6) == 0 && sb.pick_known(c)) {r, g, b} = c;
      end else if (roll < 54) begin
        m = MODE_REMOVE;
      end else if (roll < 56) begin
        m = MODE_CLEAR;
      end else begin
        m   = MODE_QUERY;
        aim = $urandom_range(0, 9);
        if (aim < 3 && sb.pick_known(c)) begin
          {r, g, b} = c;
        end else if (aim < 5 && sb.pick_known(c)) begin
          r = nudge(c[23:16]);
          g = nudge(c[15:8]);
          b = nudge(c[7:0]);
        end
      end
      send_command(m, slot, r, g, b, next_gap(), n == 0 || n == RANDOM_ITEMS / 2);
    end

    @(negedge clk);
    start <= 1'b0;

    // Let the last queries answer, then watch a while longer for stray strobes.
    guard = 0;
    while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SCAN_CYCLES + 8) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d queries never answered", sb.pending());
      sb.failures++;
    end

    if (sb.failures == 0) begin
      $display("nearest_palette_color test passed");
    end else begin
      $display("nearest_palette_color test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
